>>> src/dpr_pkg.sv
// types, codes and constants shared by the delayed packet ring buffer
`default_nettype none

package dpr_pkg;

  // picoseconds in one second
  localparam logic [39:0] PS_PER_SEC = 40'd1000000000000;

  // width of the pending count reported with each result
  localparam int unsigned PEND_W = 7;

  // opcodes
  typedef enum logic {
    OP_PUSH = 1'b0,
    OP_POLL = 1'b1
  } opcode_e;

  // result status codes
  typedef enum logic [2:0] {
    ST_STORED    = 3'd0,
    ST_OVERWRITE = 3'd1,
    ST_DELIVERED = 3'd2,
    ST_EMPTY     = 3'd3,
    ST_DEFERRED  = 3'd4
  } status_e;

  // configuration register indexes
  typedef enum logic [1:0] {
    CFG_DELAY_SEC = 2'd0,
    CFG_DELAY_PS  = 2'd1,
    CFG_MAX_CAP   = 2'd2,
    CFG_UNUSED    = 2'd3
  } cfg_idx_e;

  // one input beat
  typedef struct packed {
    logic        opcode;
    logic [1:0]  source_stream;
    logic [15:0] capture_len;
    logic [15:0] wire_len;
    logic [31:0] stamp_seconds;
    logic [39:0] stamp_picoseconds;
    logic [31:0] payload_handle;
    logic [31:0] now_seconds;
    logic [39:0] now_picoseconds;
  } in_item_t;

  // one output beat
  typedef struct packed {
    logic [2:0]  status;
    logic [31:0] out_packet_id;
    logic [1:0]  out_stream;
    logic [15:0] out_capture_len;
    logic [15:0] out_wire_len;
    logic [31:0] out_seconds;
    logic [39:0] out_picoseconds;
    logic [31:0] out_handle;
    logic [6:0]  pending_count;
  } out_item_t;

  // one stored ring slot
  typedef struct packed {
    logic [31:0] seconds;
    logic [39:0] picoseconds;
    logic [15:0] capture_len;
    logic [15:0] wire_len;
    logic [31:0] handle;
    logic [31:0] seq_id;
    logic [1:0]  stream;
  } slot_t;

  // commands from controller to datapath
  typedef struct packed {
    logic take;    // latch the input beat and start the slot read
    logic commit;  // execute the latched item and load the output register
  } ctrl_cmd_t;

endpackage

`default_nettype wire

>>> src/dpr_ram.sv
// generic simple dual-port ram with registered read
`default_nettype none

module dpr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  // registered read port
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem[raddr_i];
    end
  end

endmodule

`default_nettype wire

>>> src/dpr_ctrl.sv
// controller: input acceptance, execute step and output beat handshake
`default_nettype none

module dpr_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dpr_pkg::ctrl_cmd_t     cmd_o
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_e;

  state_e state_q, state_d;
  logic   stall_q, stall_d;
  logic   out_valid_q, out_valid_d;
  logic   take;
  logic   commit;

  // accept in idle, execute once the output register is free or draining
  assign take   = in_valid_i && !stall_q;
  assign commit = (state_q == S_EXEC) && (!out_valid_q || !out_stall_i);

  always_comb begin
    state_d     = state_q;
    stall_d     = stall_q;
    out_valid_d = out_valid_q;
    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (take) begin
          state_d = S_EXEC;
          stall_d = 1'b1;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_d     = S_IDLE;
          stall_d     = 1'b0;
          out_valid_d = 1'b1;
        end
      end
      default: begin
        state_d = S_IDLE;
        stall_d = 1'b0;
      end
    endcase
  end

  // state and registered handshake outputs
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      stall_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      stall_q     <= stall_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign in_stall_o   = stall_q;
  assign out_valid_o  = out_valid_q;
  assign cmd_o.take   = take;
  assign cmd_o.commit = commit;

endmodule

`default_nettype wire

>>> src/dpr_datapath.sv
// datapath: configuration, ring pointers, slot memory and result register
`default_nettype none

module dpr_datapath #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire dpr_pkg::ctrl_cmd_t cmd_i,
  input  wire dpr_pkg::in_item_t  in_data_i,
  output dpr_pkg::out_item_t      out_data_o,
  input  wire logic               cfg_valid_i,
  input  wire logic [1:0]         cfg_index_i,
  input  wire logic [39:0]        cfg_data_i
);

  localparam int unsigned PTR_W = $clog2(RING_DEPTH);
  localparam int unsigned CNT_W = $clog2(RING_DEPTH + 1);
  localparam int unsigned SLOT_W = $bits(dpr_pkg::slot_t);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(RING_DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(RING_DEPTH);

  // configuration registers
  logic [31:0] dly_sec_q;
  logic [39:0] dly_ps_q;
  logic [15:0] max_cap_q;

  // ring control
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic [31:0]      next_id_q, next_id_d;

  // latched item
  logic        op_q;
  logic [1:0]  stream_q;
  logic [15:0] cap_q;
  logic [15:0] wire_q;
  logic [31:0] handle_q;
  logic [31:0] sec_sum_q;
  logic [40:0] ps_sum_q;
  logic [31:0] now_sec_q;
  logic [39:0] now_ps_q;

  dpr_pkg::out_item_t out_q, out_d;
  dpr_pkg::slot_t     slot_w;
  dpr_pkg::slot_t     slot_r;
  logic [SLOT_W-1:0]  rdata;

  logic        full;
  logic        carry;
  logic [40:0] ps_fix;
  logic        early;
  logic        is_push;
  logic        ram_we;
  logic [PTR_W-1:0] rd_ptr_inc;
  logic [PTR_W-1:0] wr_ptr_inc;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dly_sec_q <= '0;
      dly_ps_q  <= '0;
      max_cap_q <= 16'hffff;
    end else if (cfg_valid_i) begin
      case (dpr_pkg::cfg_idx_e'(cfg_index_i))
        dpr_pkg::CFG_DELAY_SEC: dly_sec_q <= cfg_data_i[31:0];
        dpr_pkg::CFG_DELAY_PS:  dly_ps_q  <= cfg_data_i;
        dpr_pkg::CFG_MAX_CAP:   max_cap_q <= cfg_data_i[15:0];
        default: ;
      endcase
    end
  end

  // latch the item: clip length and add the delay on the way in
  always_ff @(posedge clk_i) begin
    if (cmd_i.take) begin
      op_q      <= in_data_i.opcode;
      stream_q  <= in_data_i.source_stream;
      cap_q     <= (in_data_i.capture_len > max_cap_q) ? max_cap_q : in_data_i.capture_len;
      wire_q    <= in_data_i.wire_len;
      handle_q  <= in_data_i.payload_handle;
      sec_sum_q <= in_data_i.stamp_seconds + dly_sec_q;
      ps_sum_q  <= {1'b0, in_data_i.stamp_picoseconds} + {1'b0, dly_ps_q};
      now_sec_q <= in_data_i.now_seconds;
      now_ps_q  <= in_data_i.now_picoseconds;
    end
  end

  // picosecond carry into seconds
  assign carry  = ps_sum_q >= {1'b0, dpr_pkg::PS_PER_SEC};
  assign ps_fix = carry ? (ps_sum_q - {1'b0, dpr_pkg::PS_PER_SEC}) : ps_sum_q;

  always_comb begin
    slot_w.seconds     = sec_sum_q + {31'd0, carry};
    slot_w.picoseconds = ps_fix[39:0];
    slot_w.capture_len = cap_q;
    slot_w.wire_len    = wire_q;
    slot_w.handle      = handle_q;
    slot_w.seq_id      = next_id_q;
    slot_w.stream      = stream_q;
  end

  // slot store, read at the head while the item is latched
  dpr_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (RING_DEPTH)
  ) u_slots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (wr_ptr_q),
    .wdata_i (slot_w),
    .re_i    (cmd_i.take),
    .raddr_i (rd_ptr_q),
    .rdata_o (rdata)
  );

  assign slot_r = dpr_pkg::slot_t'(rdata);

  // ring occupancy and due test
  assign full    = cnt_q == FULL_CNT;
  assign is_push = op_q == dpr_pkg::OP_PUSH;
  assign ram_we  = cmd_i.commit && is_push;
  assign early   = (now_sec_q < slot_r.seconds) ||
                   ((now_sec_q == slot_r.seconds) && (now_ps_q < slot_r.picoseconds));
  assign rd_ptr_inc = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
  assign wr_ptr_inc = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;

  // execute step
  always_comb begin
    rd_ptr_d  = rd_ptr_q;
    wr_ptr_d  = wr_ptr_q;
    cnt_d     = cnt_q;
    next_id_d = next_id_q;
    out_d     = '0;
    if (is_push) begin
      wr_ptr_d  = wr_ptr_inc;
      next_id_d = next_id_q + 32'd1;
      out_d.out_packet_id = next_id_q;
      if (full) begin
        // oldest entry is lost, head moves on
        rd_ptr_d     = rd_ptr_inc;
        out_d.status = dpr_pkg::ST_OVERWRITE;
      end else begin
        cnt_d        = cnt_q + 1'b1;
        out_d.status = dpr_pkg::ST_STORED;
      end
    end else if (cnt_q == '0) begin
      out_d.status = dpr_pkg::ST_EMPTY;
    end else if (early) begin
      out_d.status = dpr_pkg::ST_DEFERRED;
    end else begin
      rd_ptr_d              = rd_ptr_inc;
      cnt_d                 = cnt_q - 1'b1;
      out_d.status          = dpr_pkg::ST_DELIVERED;
      out_d.out_packet_id   = slot_r.seq_id;
      out_d.out_stream      = slot_r.stream;
      out_d.out_capture_len = slot_r.capture_len;
      out_d.out_wire_len    = slot_r.wire_len;
      out_d.out_seconds     = slot_r.seconds;
      out_d.out_picoseconds = slot_r.picoseconds;
      out_d.out_handle      = slot_r.handle;
    end
    out_d.pending_count = dpr_pkg::PEND_W'(cnt_d);
  end

  // ring control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q  <= '0;
      wr_ptr_q  <= '0;
      cnt_q     <= '0;
      next_id_q <= 32'd1;
    end else if (cmd_i.commit) begin
      rd_ptr_q  <= rd_ptr_d;
      wr_ptr_q  <= wr_ptr_d;
      cnt_q     <= cnt_d;
      next_id_q <= next_id_d;
    end
  end

  // output register
  always_ff @(posedge clk_i) begin
    if (cmd_i.commit) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

`default_nettype wire

>>> src/delayed_packet_ring_buffer.sv
// top level of the delayed packet ring buffer
//
// A ring of RING_DEPTH packet descriptors with a delayed release.
// Input channel (in_valid_i / in_stall_o / in_data_i): a beat is either a
// push, which stores one descriptor with its timestamp plus the configured
// delay, or a poll, which releases the oldest entry once the supplied time
// has reached its timestamp. Every input beat yields exactly one output beat
// on out_valid_o / out_stall_i / out_data_o, carrying the status and the
// pending count. A push into a full ring overwrites the oldest entry.
// Configuration (cfg_valid_i / cfg_ready_o): delay seconds, delay
// picoseconds and capture length limit; write only while the block is idle.
// One item is worked at a time: a first step latches the item, adds the
// delay and reads the head slot from the slot ram, a second executes and
// loads the output register; no new item is taken before the execute step
// is done. A result appears in the cycle after the execute step. While the
// receiver stalls, the finished result waits in the output register, the
// next item may already be latched, and its execute step waits for it.
// Reset empties the ring, restarts packet ids at one and restores the
// register defaults; it needs no clearing pass over the slot ram.
`default_nettype none

module delayed_packet_ring_buffer #(
  parameter int unsigned RING_DEPTH = 64
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output logic                   in_stall_o,
  input  wire dpr_pkg::in_item_t in_data_i,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output dpr_pkg::out_item_t     out_data_o,
  input  wire logic              cfg_valid_i,
  output logic                   cfg_ready_o,
  input  wire logic [1:0]        cfg_index_i,
  input  wire logic [39:0]       cfg_data_i
);

  dpr_pkg::ctrl_cmd_t cmd;

  // registers are always writable
  assign cfg_ready_o = 1'b1;

  dpr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .cmd_o       (cmd)
  );

  dpr_datapath #(
    .RING_DEPTH (RING_DEPTH)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .in_data_i   (in_data_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i && cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

endmodule

`default_nettype wire

>>> src/dpr_checker.sv
// port checker for the delayed packet ring buffer, with its bind
`default_nettype none

module dpr_checker (
  input wire logic               clk_i,
  input wire logic               rst_ni,
  input wire logic               in_valid_i,
  input wire logic               in_stall_o,
  input wire logic               out_valid_o,
  input wire logic               out_stall_i,
  input wire dpr_pkg::out_item_t out_data_o
);

  // one item in flight: an accepted beat closes the input
  a_one_in_flight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input accepted twice in a row");

  // stalled result holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_data_o)))
    else $error("stalled result changed");

  // status is a defined code
  a_status_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.status <= dpr_pkg::ST_DEFERRED))
    else $error("undefined status code");

  // an empty poll leaves nothing pending and carries no id
  a_empty_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == dpr_pkg::ST_EMPTY)) |->
    ((out_data_o.pending_count == '0) && (out_data_o.out_packet_id == '0)))
    else $error("empty result with pending entries");

  // a deferred poll only happens with entries pending
  a_deferred_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.status == dpr_pkg::ST_DEFERRED)) |->
    (out_data_o.pending_count != '0))
    else $error("deferred result with an empty ring");

endmodule

bind delayed_packet_ring_buffer dpr_checker u_dpr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);

`default_nettype wire
